/* rtl/tpm_pkg.sv */
// Shared types and constants of the trie multi-pattern matcher.
// Holds the operation and status codes and the controller/datapath command and status structs.
// No dependencies.
package tpm_pkg;

  // Fixed widths of the channel fields.
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int POS_W  = 12;
  localparam int STAT_W = 2;

  // Operation codes of an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_ADD_PAT  = 2'd0,
    OP_ADD_TEXT = 2'd1,
    OP_TEST     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Status codes of a result transaction.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NODE_FULL = 2'd1,
    ST_TEXT_FULL = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input fields
    logic sweep_wr;   // clearing pass: zero one child entry and one node row
    logic clr_start;  // clear item: reset counters, restart the clearing pass
    logic pat_rd;     // read child entry at insert cursor and symbol
    logic pat_upd;    // apply the pattern symbol from the read child entry
    logic txt_wr;     // append the text symbol
    logic tst_start;  // start a walk at the latched position
    logic txt_rd;     // read the text symbol at the walk index
    logic child_rd;   // read the child entry of the walk node and text symbol
    logic node_rd;    // read the end mark and child flag of the reached node
    logic step;       // advance the walk one edge
    logic res_hit;    // stage a match result
    logic res_miss;   // stage a no-match result
    logic out_load;   // move the staged result into the output register
  } tpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // clearing pass is at its last entry
    logic pos_ok;      // start position lies inside the stored text
    logic child_zero;  // walk found no edge for the text symbol
    logic walk_hit;    // reached node ends a pattern or is a leaf
    logic idx_last;    // walk index is at the last text symbol
  } tpm_stat_t;

endpackage

/* rtl/tpm_in_if.sv */
// Input channel interface of the trie multi-pattern matcher.
// Carries valid, ready and the input item fields; depends on tpm_pkg.
interface tpm_in_if import tpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SYM_W-1:0] symbol;
  logic             last_of_pattern;
  logic [POS_W-1:0] position;

  modport source (output valid, output operation, output symbol,
                  output last_of_pattern, output position, input ready);
  modport sink   (input valid, input operation, input symbol,
                  input last_of_pattern, input position, output ready);
endinterface

/* rtl/tpm_out_if.sv */
// Result channel interface of the trie multi-pattern matcher.
// Carries valid, ready and the result fields; depends on tpm_pkg.
interface tpm_out_if import tpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              match;
  logic [STAT_W-1:0] status;

  modport source (output valid, output match, output status, input ready);
  modport sink   (input valid, input match, input status, output ready);
endinterface

/* rtl/tpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tpm_ctrl.sv */
// Controller of the trie multi-pattern matcher: sequences each operation and the
// clearing pass, and owns the channel handshakes. Depends on tpm_pkg.
module tpm_ctrl import tpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  op_t       in_op,
  output logic      out_valid,
  input  logic      out_ready,
  output tpm_cmd_t  cmd,
  input  tpm_stat_t stat
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_PAT_RD,
    S_PAT_UPD,
    S_TXT,
    S_TST_START,
    S_TST_TXT,
    S_TST_CHILD,
    S_TST_NODE,
    S_TST_EVAL,
    S_CLR
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   push;
  logic   finish;

  // A new item is taken when the block is idle and the staging slot is free.
  assign in_ready = (state_r == S_IDLE) && !pend_r;
  assign accept   = in_valid && in_ready;
  assign push     = pend_r && (!out_valid_r || out_ready);

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    finish    = 1'b0;
    cmd.out_load = push;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (in_op)
            OP_ADD_PAT:  state_nxt = S_PAT_RD;
            OP_ADD_TEXT: state_nxt = S_TXT;
            OP_TEST:     state_nxt = S_TST_START;
            OP_CLEAR:    state_nxt = S_CLR;
          endcase
        end
      end
      S_PAT_RD: begin
        cmd.pat_rd = 1'b1;
        state_nxt  = S_PAT_UPD;
      end
      S_PAT_UPD: begin
        cmd.pat_upd = 1'b1;
        finish      = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_TXT: begin
        cmd.txt_wr = 1'b1;
        finish     = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_TST_START: begin
        if (stat.pos_ok) begin
          cmd.tst_start = 1'b1;
          state_nxt     = S_TST_TXT;
        end else begin
          cmd.res_miss = 1'b1;
          finish       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TST_TXT: begin
        cmd.txt_rd = 1'b1;
        state_nxt  = S_TST_CHILD;
      end
      S_TST_CHILD: begin
        cmd.child_rd = 1'b1;
        state_nxt    = S_TST_NODE;
      end
      S_TST_NODE: begin
        if (stat.child_zero) begin
          cmd.res_miss = 1'b1;
          finish       = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_TST_EVAL;
        end
      end
      S_TST_EVAL: begin
        priority if (stat.walk_hit) begin
          cmd.res_hit = 1'b1;
          finish      = 1'b1;
          state_nxt   = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.res_miss = 1'b1;
          finish       = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_TST_TXT;
        end
      end
      S_CLR: begin
        cmd.clr_start = 1'b1;
        finish        = 1'b1;
        state_nxt     = S_SWEEP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    pend_nxt      = finish || (pend_r && !push);
    out_valid_nxt = push || (out_valid_r && !out_ready);
  end

  // State and handshake registers; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/tpm_datapath.sv */
// Datapath of the trie multi-pattern matcher: child table, node marks and text
// memories, insert and walk registers, and the result registers.
// Depends on tpm_pkg and tpm_ram.
module tpm_datapath import tpm_pkg::*; #(
  parameter int NODES       = 256,
  parameter int TEXT_MAX    = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tpm_cmd_t         cmd,
  output tpm_stat_t        stat,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_last,
  input  logic [POS_W-1:0] in_position,
  output logic             out_match,
  output status_t          out_status
);

  localparam int NODE_W      = $clog2(NODES);
  localparam int CNT_W       = $clog2(NODES + 1);
  localparam int CA_W        = NODE_W + SYMBOL_BITS;
  localparam int CHILD_DEPTH = NODES * (2 ** SYMBOL_BITS);
  localparam int TLEN_W      = $clog2(TEXT_MAX + 1);
  localparam int TEXT_AW     = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int CMP_W       = (TLEN_W > POS_W) ? TLEN_W : POS_W;

  // Latched item fields.
  logic [SYMBOL_BITS-1:0] sym_r;
  logic                   last_r;
  logic [POS_W-1:0]       pos_r;

  // Trie build, text and walk state.
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TLEN_W-1:0] len_r, len_nxt;
  logic [CA_W-1:0]   sweep_r, sweep_nxt;
  logic [TLEN_W-1:0] idx_r, idx_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] next_r, next_nxt;

  // Staged and output results.
  logic    res_match_r, res_match_nxt;
  status_t res_status_r, res_status_nxt;
  logic    out_match_r;
  status_t out_status_r;

  // Memory ports.
  logic                   child_we, child_re;
  logic [CA_W-1:0]        child_waddr, child_raddr;
  logic [NODE_W-1:0]      child_wdata, child_q;
  logic                   end_we, kids_we;
  logic [NODE_W-1:0]      end_waddr, kids_waddr;
  logic                   end_q, kids_q;
  logic                   text_we;
  logic [SYMBOL_BITS-1:0] text_q;

  logic [NODE_W-1:0] sweep_row;
  logic              child_new;
  logic              node_full;
  logic [NODE_W-1:0] pat_next;
  logic              txt_full;
  logic              pat_ok;

  // Pattern insert decisions from the child entry just read.
  assign child_new = (child_q == '0);
  assign node_full = child_new && (count_r == CNT_W'(NODES));
  assign pat_next  = child_new ? count_r[NODE_W-1:0] : child_q;
  assign pat_ok    = cmd.pat_upd && !node_full;
  assign txt_full  = (len_r == TLEN_W'(TEXT_MAX));
  assign sweep_row = sweep_r[CA_W-1:SYMBOL_BITS];

  // Status toward the controller.
  assign stat.sweep_last = (sweep_r == CA_W'(CHILD_DEPTH - 1));
  assign stat.pos_ok     = (CMP_W'(pos_r) < CMP_W'(len_r));
  assign stat.child_zero = (child_q == '0);
  assign stat.walk_hit   = end_q || !kids_q;
  assign stat.idx_last   = (({1'b0, idx_r} + (TLEN_W + 1)'(1)) >= {1'b0, len_r});

  // Next values of the build, text and walk registers.
  always_comb begin
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    sweep_nxt  = sweep_r;
    idx_nxt    = idx_r;
    node_nxt   = node_r;
    next_nxt   = next_r;
    if (cmd.clr_start) begin
      cursor_nxt = '0;
      count_nxt  = CNT_W'(1);
      len_nxt    = '0;
      sweep_nxt  = '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_nxt = sweep_r + CA_W'(1);
      end
      if (pat_ok) begin
        cursor_nxt = last_r ? '0 : pat_next;
        if (child_new) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      if (cmd.txt_wr && !txt_full) begin
        len_nxt = len_r + TLEN_W'(1);
      end
    end
    // A walk only starts inside the stored text, so the position fits the index.
    if (cmd.tst_start) begin
      idx_nxt  = TLEN_W'(pos_r);
      node_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt  = idx_r + TLEN_W'(1);
      node_nxt = next_r;
    end
    if (cmd.node_rd) begin
      next_nxt = child_q;
    end
  end

  // Next staged result.
  always_comb begin
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    priority if (cmd.clr_start) begin
      res_match_nxt  = 1'b0;
      res_status_nxt = ST_OK;
    end else if (cmd.pat_upd) begin
      res_match_nxt  = 1'b0;
      res_status_nxt = node_full ? ST_NODE_FULL : ST_OK;
    end else if (cmd.txt_wr) begin
      res_match_nxt  = 1'b0;
      res_status_nxt = txt_full ? ST_TEXT_FULL : ST_OK;
    end else if (cmd.res_hit) begin
      res_match_nxt  = 1'b1;
      res_status_nxt = ST_OK;
    end else if (cmd.res_miss) begin
      res_match_nxt  = 1'b0;
      res_status_nxt = ST_OK;
    end else begin
      res_match_nxt  = res_match_r;
      res_status_nxt = res_status_r;
    end
  end

  // Counters and cursor, set to their start values by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      count_r  <= CNT_W'(1);
      len_r    <= '0;
      sweep_r  <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      sweep_r  <= sweep_nxt;
    end
  end

  // Payload registers: item fields, walk state and results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_r  <= in_symbol[SYMBOL_BITS-1:0];
      last_r <= in_last;
      pos_r  <= in_position;
    end
    idx_r        <= idx_nxt;
    node_r       <= node_nxt;
    next_r       <= next_nxt;
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.out_load) begin
      out_match_r  <= res_match_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_match  = out_match_r;
  assign out_status = out_status_r;

  // Child table: cleared by the sweep, written on a new edge.
  assign child_we    = cmd.sweep_wr || (pat_ok && child_new);
  assign child_waddr = cmd.sweep_wr ? sweep_r : {cursor_r, sym_r};
  assign child_wdata = cmd.sweep_wr ? '0 : pat_next;
  assign child_re    = cmd.pat_rd || cmd.child_rd;
  assign child_raddr = cmd.pat_rd ? {cursor_r, sym_r} : {node_r, text_q};

  tpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_q)
  );

  // Pattern end marks, one bit per node.
  assign end_we    = cmd.sweep_wr || (pat_ok && last_r);
  assign end_waddr = cmd.sweep_wr ? sweep_row : pat_next;

  tpm_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (!cmd.sweep_wr),
    .re    (cmd.node_rd),
    .raddr (child_q),
    .rdata (end_q)
  );

  // Child-present flags, one bit per node.
  assign kids_we    = cmd.sweep_wr || (pat_ok && child_new);
  assign kids_waddr = cmd.sweep_wr ? sweep_row : cursor_r;

  tpm_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_kids_ram (
    .clk   (clk),
    .we    (kids_we),
    .waddr (kids_waddr),
    .wdata (!cmd.sweep_wr),
    .re    (cmd.node_rd),
    .raddr (child_q),
    .rdata (kids_q)
  );

  // Text store, appended at the current length.
  assign text_we = cmd.txt_wr && !txt_full;

  tpm_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (TEXT_MAX)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (len_r[TEXT_AW-1:0]),
    .wdata (sym_r),
    .re    (cmd.txt_rd),
    .raddr (idx_r[TEXT_AW-1:0]),
    .rdata (text_q)
  );

  // The node count stays between the root alone and a full store.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(NODES)))
    else $error("node count out of range");

  // The insert cursor always names an allocated node.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cursor_r) < count_r)
    else $error("insert cursor beyond allocated nodes");

  // The text length never passes the store size.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= TLEN_W'(TEXT_MAX))
    else $error("text length beyond store size");

  // A walk only reads text that has been written.
  a_walk_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.txt_rd |-> (idx_r < len_r))
    else $error("walk reads beyond the stored text");

endmodule

/* rtl/trie_multi_pattern_matcher.sv */
// Trie multi-pattern matcher. Each input transaction carries one operation: a pattern
// symbol (a child table read, then the update), a text symbol (an append to the text
// store), a test of a start position (a position check, then for each trie edge walked a
// text read, a child table read and a node mark read in turn, with no mark read for an
// edge that turns out to be missing) or a clear (a counter reset, then the clearing
// pass). After the last state of each operation the finished result moves from a
// staging register into the output register; a result waiting there does not hold up
// the next item, but while it waits the next finished result stays staged and no
// further item is taken. Every transaction gives one result transaction. After reset
// and after every clear, a clearing pass zeroes the child table and the node marks
// one entry a cycle, during which no item is taken. Depends on tpm_pkg, the channel
// interfaces, tpm_ram, tpm_ctrl and tpm_datapath.
module trie_multi_pattern_matcher import tpm_pkg::*; #(
  parameter int NODES       = 256,
  parameter int TEXT_MAX    = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  tpm_in_if.sink in_ch,
  tpm_out_if.source out_ch
);

  tpm_cmd_t  cmd;
  tpm_stat_t stat;
  status_t   out_status;

  // Sequencing and handshakes.
  tpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (op_t'(in_ch.operation)),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Memories and registers.
  tpm_datapath #(
    .NODES       (NODES),
    .TEXT_MAX    (TEXT_MAX),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_symbol   (in_ch.symbol),
    .in_last     (in_ch.last_of_pattern),
    .in_position (in_ch.position),
    .out_match   (out_ch.match),
    .out_status  (out_status)
  );

  assign out_ch.status = out_status;

endmodule
